// File: sv/skst_pkg.sv
// Shared types, constants and helpers for the slot key set table.
// No dependencies; imported by every other file of the block.
package skst_pkg;

  // Table geometry
  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int ACT_W    = (IDX_W > 5) ? IDX_W : 5;

  localparam logic [31:0] EMPTY_KEY = 32'hFFFF_FFFF;

  // slots_in_use register: reset value and clamp
  localparam logic [4:0] SIU_RESET = (CAPACITY < 16) ? 5'(CAPACITY) : 5'd16;
  localparam logic [4:0] SIU_CLAMP = (CAPACITY < 31) ? 5'(CAPACITY) : 5'd31;

  // Register map (word index taken from paddr[2])
  localparam logic REG_SLOTS_IN_USE = 1'b0;

  // Operation codes; the unused code behaves as a query
  localparam logic [1:0] KIND_QUERY  = 2'd0;
  localparam logic [1:0] KIND_ADD    = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] key;
    logic        check_duplicate;
  } in_item_t;

  typedef struct packed {
    logic       ok;
    logic       found;
    logic [3:0] hit_slot;
    logic       free_found;
    logic [3:0] free_slot;
  } out_item_t;

  // Search token handed from cell to cell
  typedef struct packed {
    logic [1:0]       kind;
    logic [31:0]      key;
    logic             check;
    logic             match;
    logic [IDX_W-1:0] match_slot;
    logic             free_found;
    logic [IDX_W-1:0] free_slot;
  } scan_t;

  // Slot write broadcast to all cells
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [31:0]      key;
  } slot_wr_t;

  // Low four bits of a slot index, zero-extended when the index is narrower
  function automatic logic [3:0] slot4(input logic [IDX_W-1:0] idx);
    logic [IDX_W+3:0] ext;
    ext = {4'b0000, idx};
    return ext[3:0];
  endfunction

endpackage

// File: sv/skst_cell.sv
// One slot of the table: holds a key and compares it against the passing token.
// Depends on skst_pkg.
module skst_cell
  import skst_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] slot_idx_i,
  input  logic [ACT_W-1:0] n_active_i,
  input  slot_wr_t         wr_i,
  input  logic             tok_vld_i,
  input  scan_t            tok_i,
  output logic             tok_vld_o,
  output scan_t            tok_o
);

  logic [31:0] key_r;
  logic        vld_r;
  scan_t       tok_r;
  scan_t       tok_nxt;
  logic        active;
  logic        is_empty;

  // Fold this slot into the running first-match / first-free result
  always_comb begin
    active   = (ACT_W'(slot_idx_i) < n_active_i);
    is_empty = (tok_i.key == EMPTY_KEY);
    tok_nxt  = tok_i;
    if (active) begin
      if (!tok_i.match && !is_empty && (key_r == tok_i.key)) begin
        tok_nxt.match      = 1'b1;
        tok_nxt.match_slot = slot_idx_i;
      end
      if (!tok_i.free_found && (key_r == EMPTY_KEY)) begin
        tok_nxt.free_found = 1'b1;
        tok_nxt.free_slot  = slot_idx_i;
      end
    end
  end

  // Slot storage, cleared to the empty marker at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= EMPTY_KEY;
    end else if (wr_i.en && (wr_i.idx == slot_idx_i)) begin
      key_r <= wr_i.key;
    end
  end

  // Token hand-off to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= tok_vld_i;
    end
  end

  always_ff @(posedge clk) begin
    tok_r <= tok_nxt;
  end

  assign tok_vld_o = vld_r;
  assign tok_o     = tok_r;

endmodule

// File: sv/slot_key_set_table_top.sv
// Top level of the slot key set table: input/result channels, config port,
// the chain of slot cells and the result logic. Depends on skst_pkg, skst_cell.
//
// Usage:
//   in_*  : one operation per transfer (query, add, remove) with a 32-bit key.
//   out_* : one result per operation, in order.
//   cfg_* : APB-style register port; slots_in_use at byte address 0. A write
//           that does not raise slots_in_use is ignored; values above the
//           table size are clamped.
// A search token walks the row of CAPACITY cells, one cell per cycle, from the
// launch register to the holding register and then the output register. One
// item is in the chain at a time; in_stall is high from input transfer until
// its result enters the output register, so a new item is taken only after
// the result of the last one has left the holding register.
// The slot write of an add or remove happens as the token leaves the chain.
// A finished result waits in a holding register while out_stall is high, and
// the output register holds steady; the input stays stalled until it moves on.
// Reset (synchronous, rst_n low) empties every slot, sets slots_in_use to 16
// and drops all valids.
module slot_key_set_table_top
  import skst_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic        busy_r;
  logic        head_vld_r;
  scan_t       head_r;
  logic [4:0]  siu_r;
  logic [4:0]  siu_wr;
  logic        res_vld_r;
  out_item_t   res_r;
  out_item_t   res_nxt;
  logic        out_vld_r;
  out_item_t   out_r;
  logic        in_xfer;
  logic        res_move;
  logic        cfg_wr;
  slot_wr_t    wr;
  logic        tail_empty_key;
  logic        tok_vld [CAPACITY+1];
  scan_t       tok     [CAPACITY+1];

  assign in_xfer  = in_valid && !in_stall;
  assign in_stall = busy_r;
  assign res_move = res_vld_r && (!out_vld_r || !out_stall);

  // Configuration register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite &&
                      (cfg_paddr[2] == REG_SLOTS_IN_USE);
  assign siu_wr     = (32'(cfg_pwdata[4:0]) > 32'(CAPACITY)) ? SIU_CLAMP : cfg_pwdata[4:0];
  assign cfg_prdata = (cfg_paddr[2] == REG_SLOTS_IN_USE) ? {27'd0, siu_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      siu_r <= SIU_RESET;
    end else if (cfg_wr && (siu_wr > siu_r)) begin
      siu_r <= siu_wr;
    end
  end

  // Launch register: new token with an empty result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_vld_r <= 1'b0;
    end else begin
      head_vld_r <= in_xfer;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      head_r.kind       <= in_data.kind;
      head_r.key        <= in_data.key;
      head_r.check      <= in_data.check_duplicate;
      head_r.match      <= 1'b0;
      head_r.match_slot <= '0;
      head_r.free_found <= 1'b0;
      head_r.free_slot  <= '0;
    end
  end

  assign tok_vld[0] = head_vld_r;
  assign tok[0]     = head_r;

  // Row of slot cells
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    skst_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .slot_idx_i (IDX_W'(g)),
      .n_active_i (ACT_W'(siu_r)),
      .wr_i       (wr),
      .tok_vld_i  (tok_vld[g]),
      .tok_i      (tok[g]),
      .tok_vld_o  (tok_vld[g+1]),
      .tok_o      (tok[g+1])
    );
  end

  // Result and slot write from the finished token
  always_comb begin
    tail_empty_key     = (tok[CAPACITY].key == EMPTY_KEY);
    wr.en              = 1'b0;
    wr.idx             = tok[CAPACITY].free_slot;
    wr.key             = tok[CAPACITY].key;
    res_nxt.ok         = 1'b0;
    res_nxt.found      = tok[CAPACITY].match;
    res_nxt.hit_slot   = tok[CAPACITY].match ? slot4(tok[CAPACITY].match_slot) : 4'd0;
    res_nxt.free_found = tok[CAPACITY].free_found;
    res_nxt.free_slot  = slot4(tok[CAPACITY].free_slot);
    unique case (tok[CAPACITY].kind)
      KIND_ADD: begin
        if (!tail_empty_key && !(tok[CAPACITY].check && tok[CAPACITY].match) &&
            tok[CAPACITY].free_found) begin
          wr.en            = tok_vld[CAPACITY];
          res_nxt.ok       = 1'b1;
          res_nxt.hit_slot = slot4(tok[CAPACITY].free_slot);
        end
      end
      KIND_REMOVE: begin
        if (tail_empty_key) begin
          // empty marker: first free slot counts as the match, store unchanged
          res_nxt.ok       = tok[CAPACITY].free_found;
          res_nxt.hit_slot = tok[CAPACITY].free_found ?
                             slot4(tok[CAPACITY].free_slot) : 4'd0;
        end else if (tok[CAPACITY].match) begin
          wr.en      = tok_vld[CAPACITY];
          wr.idx     = tok[CAPACITY].match_slot;
          wr.key     = EMPTY_KEY;
          res_nxt.ok = 1'b1;
        end
      end
      default: begin
        res_nxt.ok = tok[CAPACITY].match;
      end
    endcase
  end

  // Holding register and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
      busy_r    <= 1'b0;
    end else begin
      if (tok_vld[CAPACITY]) begin
        res_vld_r <= 1'b1;
      end else if (res_move) begin
        res_vld_r <= 1'b0;
      end
      if (res_move) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
      if (in_xfer) begin
        busy_r <= 1'b1;
      end else if (res_move) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tok_vld[CAPACITY]) begin
      res_r <= res_nxt;
    end
    if (res_move) begin
      out_r <= res_r;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

// File: sv/skst_checker.sv
// Port-level checker for the slot key set table, bound to the top level.
// Depends on skst_pkg and slot_key_set_table_top.
module skst_checker
  import skst_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // One item in flight: the input stalls right after a transfer
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after transfer");

  // Success without a match needs a free slot (add, or remove of empty marker)
  a_ok_needs_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.ok && !out_data.found |-> out_data.free_found)
    else $error("ok without match or free slot");

  // No free slot reports slot zero
  a_free_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.free_found |-> out_data.free_slot == 4'd0)
    else $error("free_slot nonzero without free slot");

endmodule

bind slot_key_set_table_top skst_checker u_skst_checker (.*);

// File: sim/tb_slot_key_set_table_top.sv
`timescale 1ns / 1ps
// Testbench for slot_key_set_table_top: directed and random table operations,
// a shadow table for prediction, and an APB register check. Needs skst_pkg.
module tb_slot_key_set_table_top;
  import skst_pkg::*;

  // Timing and register map
  localparam int          LATENCY           = CAPACITY + 3;
  localparam logic [2:0]  ADDR_SLOTS_IN_USE = 3'd0;
  localparam logic [2:0]  ADDR_UNMAPPED     = 3'd4;
  localparam logic [1:0]  KIND_UNUSED       = 2'd3;
  localparam int          POOL_SIZE         = 12;
  localparam int          MAX_GAP           = 20;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Shadow copy of the table and its register
  logic [31:0] table_keys [CAPACITY];
  logic [4:0]  active_slots = SIU_RESET;
  logic [31:0] key_pool [POOL_SIZE];

  out_item_t   expected_results [$];
  int          error_count = 0;
  int          in_idle_pct = 0;
  int          out_stall_pct = 0;

  slot_key_set_table_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial forever #6 clk = ~clk;

  // Run limit
  initial begin
    #10_000_000;
    $display("** slot_key_set_table_top: FAILED **");
    $finish;
  end

  // Random receiver stall
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < out_stall_pct);
  end

  // Search the active slots as they stand, then apply the operation
  function automatic out_item_t predict_table_op(in_item_t op);
    out_item_t res;
    logic      is_empty;
    logic      match;
    logic      free_found;
    int        match_slot;
    int        free_slot;
    int        n;
    res        = '0;
    is_empty   = (op.key == EMPTY_KEY);
    match      = 1'b0;
    free_found = 1'b0;
    match_slot = 0;
    free_slot  = 0;
    n = (active_slots > CAPACITY) ? CAPACITY : int'(active_slots);
    for (int i = 0; i < n; i++) begin
      if (!match && !is_empty && table_keys[i] == op.key) begin
        match      = 1'b1;
        match_slot = i;
      end
      if (!free_found && table_keys[i] == EMPTY_KEY) begin
        free_found = 1'b1;
        free_slot  = i;
      end
    end
    case (op.kind)
      KIND_ADD: begin
        if (!is_empty && !(op.check_duplicate && match) && free_found) begin
          table_keys[free_slot] = op.key;
          res.ok       = 1'b1;
          res.hit_slot = 4'(free_slot);
        end else begin
          res.hit_slot = match ? 4'(match_slot) : 4'd0;
        end
      end
      KIND_REMOVE: begin
        // empty marker: the first free slot stands in as the match
        if (is_empty) begin
          res.ok       = free_found;
          res.hit_slot = free_found ? 4'(free_slot) : 4'd0;
        end else if (match) begin
          table_keys[match_slot] = EMPTY_KEY;
          res.ok       = 1'b1;
          res.hit_slot = 4'(match_slot);
        end
      end
      default: begin
        // query and the unused code
        res.ok       = match;
        res.hit_slot = match ? 4'(match_slot) : 4'd0;
      end
    endcase
    res.found      = match;
    res.free_found = free_found;
    res.free_slot  = 4'(free_slot);
    return res;
  endfunction

  function automatic void check_field(string name, logic [3:0] want, logic [3:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      error_count++;
    end
  endfunction

  // Result checker
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, out_data);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("ok", 4'(want.ok), 4'(out_data.ok));
        check_field("found", 4'(want.found), 4'(out_data.found));
        check_field("hit_slot", want.hit_slot, out_data.hit_slot);
        check_field("free_found", 4'(want.free_found), 4'(out_data.free_found));
        check_field("free_slot", want.free_slot, out_data.free_slot);
      end
    end
  end

  // One input transfer; valid stays high afterwards until idle_input or the next idle gap
  task automatic send_item(input in_item_t item);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < in_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    expected_results.push_back(predict_table_op(item));
  endtask

  task automatic send_op(input logic [1:0] kind, input logic [31:0] key, input logic chk);
    in_item_t item;
    item.kind            = kind;
    item.key             = key;
    item.check_duplicate = chk;
    send_item(item);
  endtask

  task automatic idle_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_results_drained();
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // APB access: setup then access; reads are checked against the shadow register
  task automatic cfg_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
    logic [4:0] n;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (wr) begin
      // only raising writes take effect, clamped to the table size
      if (addr == ADDR_SLOTS_IN_USE) begin
        n = data[4:0];
        if (n > CAPACITY) n = 5'(CAPACITY);
        if (n > active_slots) active_slots = n;
      end
    end else if (cfg_prdata !== {27'd0, active_slots}) begin
      $display("%0t: slots_in_use readback mismatch, expected %0d, actual %0d",
               $time, active_slots, cfg_prdata);
      error_count++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Quiet the block, then write and read back the register
  task automatic settle_and_configure(input logic [31:0] value);
    idle_input();
    wait_results_drained();
    repeat (LATENCY) @(posedge clk);
    cfg_access(1'b1, ADDR_SLOTS_IN_USE, value);
    cfg_access(1'b0, ADDR_SLOTS_IN_USE, '0);
  endtask

  task automatic test_config_port();
    cfg_access(1'b0, ADDR_SLOTS_IN_USE, '0);
    cfg_access(1'b1, ADDR_SLOTS_IN_USE, 32'd0);
    cfg_access(1'b1, ADDR_SLOTS_IN_USE, 32'd1);
    cfg_access(1'b1, ADDR_SLOTS_IN_USE, 32'd8);
    cfg_access(1'b1, ADDR_SLOTS_IN_USE, 32'(CAPACITY));
    cfg_access(1'b1, ADDR_SLOTS_IN_USE, 32'd31);
    // upper bits must be dropped
    cfg_access(1'b1, ADDR_SLOTS_IN_USE, 32'hFFFF_FFE1);
    cfg_access(1'b1, ADDR_UNMAPPED, 32'd5);
    cfg_access(1'b0, ADDR_SLOTS_IN_USE, '0);
  endtask

  task automatic test_directed_ops();
    in_idle_pct   = 0;
    out_stall_pct = 0;
    // empty table
    send_op(KIND_QUERY, 32'h0, 1'b0);
    send_op(KIND_QUERY, EMPTY_KEY, 1'b0);
    send_op(KIND_REMOVE, EMPTY_KEY, 1'b0);
    send_op(KIND_ADD, EMPTY_KEY, 1'b1);
    send_op(KIND_REMOVE, 32'h0, 1'b0);
    // duplicate refused, then allowed
    send_op(KIND_ADD, 32'h0, 1'b1);
    send_op(KIND_ADD, 32'h0, 1'b1);
    send_op(KIND_ADD, 32'h0, 1'b0);
    send_op(KIND_ADD, 32'hFFFF_FFFE, 1'b1);
    send_op(KIND_ADD, 32'h5A5A_A5A5, 1'b0);
    send_op(KIND_QUERY, 32'h0, 1'b1);
    send_op(KIND_UNUSED, 32'hFFFF_FFFE, 1'b1);
    send_op(KIND_REMOVE, 32'h0, 1'b1);
    send_op(KIND_QUERY, 32'h0, 1'b0);
    // empty marker on remove picks the hole at slot 0
    send_op(KIND_REMOVE, EMPTY_KEY, 1'b1);
    send_op(KIND_ADD, 32'h1234_5678, 1'b0);
    send_op(KIND_REMOVE, 32'hFFFF_FFFE, 1'b0);
    send_op(KIND_QUERY, 32'hFFFF_FFFE, 1'b0);
    send_op(KIND_UNUSED, EMPTY_KEY, 1'b0);
    send_op(KIND_REMOVE, 32'h0, 1'b0);
    send_op(KIND_REMOVE, 32'h0, 1'b0);
  endtask

  // Mostly pool keys so adds, hits and removes meet; add_bias steers fill level
  task automatic test_random_ops(input int count, input int idle_pct,
                                 input int stall_pct, input int add_bias);
    in_item_t item;
    int       r;
    in_idle_pct   = idle_pct;
    out_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < add_bias) begin
        item.kind = KIND_ADD;
      end else begin
        r = $urandom_range(9);
        item.kind = (r < 5) ? KIND_REMOVE : (r < 9) ? KIND_QUERY : KIND_UNUSED;
      end
      r = $urandom_range(99);
      if (r < 70) item.key = key_pool[$urandom_range(POOL_SIZE - 1)];
      else if (r < 80) item.key = EMPTY_KEY;
      else item.key = $urandom;
      item.check_duplicate = 1'($urandom_range(1));
      // occasional full pause until the pipeline is empty
      if ($urandom_range(39) == 0) begin
        idle_input();
        wait_results_drained();
      end
      send_item(item);
    end
  endtask

  initial begin
    for (int i = 0; i < CAPACITY; i++) table_keys[i] = EMPTY_KEY;
    key_pool[0] = 32'h0;
    key_pool[1] = 32'hFFFF_FFFE;
    for (int i = 2; i < POOL_SIZE; i++) begin
      key_pool[i] = $urandom;
      if (key_pool[i] == EMPTY_KEY) key_pool[i] = 32'h1;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_config_port();
    test_directed_ops();
    settle_and_configure(32'd1);
    test_random_ops(150, 0, 0, 60);
    settle_and_configure(32'd31);
    test_random_ops(145, 63, 0, 20);
    settle_and_configure(32'd0);
    test_random_ops(145, 0, 63, 70);
    settle_and_configure(32'(CAPACITY));
    test_random_ops(145, 25, 25, 40);

    idle_input();
    wait_results_drained();
    repeat (LATENCY * 4) @(posedge clk);
    if (expected_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("** slot_key_set_table_top: PASSED **");
    end else begin
      $display("** slot_key_set_table_top: FAILED **");
    end
    $finish;
  end

endmodule
